### rtl/bpa_pkg.sv
// Shared codes and field widths for the bitmap page allocator.
package bpa_pkg;

    // Fixed field widths
    localparam int TYPE_W  = 3;
    localparam int PCNT_W  = 11;
    localparam int SHIFT_W = 5;
    localparam int STAT_W  = 2;
    localparam int FRAG_W  = 7;
    localparam int CIDX_W  = 2;

    typedef logic [TYPE_W-1:0] t_req_type;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CIDX_W-1:0] t_cfg_idx;

    // Request kinds
    localparam t_req_type REQ_ALLOC = 3'd0;
    localparam t_req_type REQ_ALIGN = 3'd1;
    localparam t_req_type REQ_AT    = 3'd2;
    localparam t_req_type REQ_FREE  = 3'd3;
    localparam t_req_type REQ_QUERY = 3'd4;
    localparam t_req_type REQ_STATS = 3'd5;
    localparam t_req_type REQ_RSTAT = 3'd6;
    localparam t_req_type REQ_INIT  = 3'd7;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_BAD   = 2'd1;
    localparam t_status ST_NOFIT = 2'd2;
    localparam t_status ST_BUSY  = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_BASE  = 2'd0;
    localparam t_cfg_idx CFG_SHIFT = 2'd1;
    localparam t_cfg_idx CFG_TOTAL = 2'd2;
    localparam t_cfg_idx CFG_RESV  = 2'd3;

    // Scale for the fragmentation percentage
    localparam int PCT_SCALE = 100;

endpackage

### rtl/bpa_bitmap.sv
// One-bit-per-page map memory with one write port and a registered read port.
module bpa_bitmap
    import bpa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int IW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    // Write one page bit
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one page bit, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bpa_div.sv
// Restoring divider, one quotient bit per cycle.
module bpa_div
    import bpa_pkg::*;
#(
    parameter int DW = 17,
    parameter int VW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int KW = $clog2(DW + 1);

    logic          r_busy;
    logic [KW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW:0]   r_r;
    logic [VW-1:0] r_d;
    logic [VW:0]   sh;
    logic          fits;

    // Shift in the next dividend bit and try the subtract
    assign sh   = {r_r[VW-1:0], r_q[DW-1]};
    assign fits = sh >= {1'b0, r_d};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= KW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - KW'(1);
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_r <= fits ? (sh - {1'b0, r_d}) : sh;
            r_q <= {r_q[DW-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r[VW-1:0];

endmodule

### rtl/bitmap_page_allocator_top.sv
// Bitmap page allocator top level: request sequencer, page map and shared divider.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+------------------------------
//  request  | i_req_type i_page_count i_target_address | i_start & !o_busy
//           | i_alignment_bytes                        |
//  result   | o_status o_result_address ... counters   | o_done, one cycle, no stall
//  config   | i_cfg_index i_cfg_data                   | i_cfg_valid & o_cfg_ready
//
// A request walks the page map one bit at a time through a single read port.
// Plain alloc: a divide for the start page, a scan of up to 2*T pages, each read
// then evaluated, then the run is marked page by page. Aligned alloc adds a second
// divide and rescans each aligned candidate. Stats scan T pages, then a divide.
// Init writes every page. After reset the map is cleared with o_busy high.
// Results are never held off; o_done lasts one cycle.
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES  = 1024,
    parameter int ADDR_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_req_type             i_req_type,
    input  logic [PCNT_W-1:0]     i_page_count,
    input  logic [ADDR_BITS-1:0]  i_target_address,
    input  logic [ADDR_BITS-1:0]  i_alignment_bytes,
    output logic                  o_done,
    output t_status               o_status,
    output logic [ADDR_BITS-1:0]  o_result_address,
    output logic                  o_page_is_allocated,
    output logic [PCNT_W-1:0]     o_free_pages,
    output logic [PCNT_W-1:0]     o_used_pages,
    output logic [PCNT_W-1:0]     o_largest_free_run,
    output logic [FRAG_W-1:0]     o_fragmentation_percent,
    output logic [COUNT_BITS-1:0] o_alloc_total,
    output logic [COUNT_BITS-1:0] o_free_total,
    output logic [COUNT_BITS-1:0] o_failure_total,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [ADDR_BITS-1:0]  i_cfg_data
);

    localparam int AW = ADDR_BITS;
    localparam int CB = COUNT_BITS;
    localparam int PW = $clog2(NUM_PAGES + 1);
    localparam int IW = $clog2(NUM_PAGES);
    localparam int WW = ((PW > PCNT_W) ? PW : PCNT_W) + 1;
    localparam int XW = AW + PW;
    localparam int VW = (AW > PW) ? AW : PW;
    localparam int DW = $clog2(PCT_SCALE * NUM_PAGES + 1);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_PREP  = 5'd2;
    localparam logic [4:0] S_DIVS  = 5'd3;
    localparam logic [4:0] S_DIVA  = 5'd4;
    localparam logic [4:0] S_PRD   = 5'd5;
    localparam logic [4:0] S_PEV   = 5'd6;
    localparam logic [4:0] S_ASTEP = 5'd7;
    localparam logic [4:0] S_ARD   = 5'd8;
    localparam logic [4:0] S_AEV   = 5'd9;
    localparam logic [4:0] S_CRD   = 5'd10;
    localparam logic [4:0] S_CEV   = 5'd11;
    localparam logic [4:0] S_MARK  = 5'd12;
    localparam logic [4:0] S_FIN   = 5'd13;
    localparam logic [4:0] S_QRD   = 5'd14;
    localparam logic [4:0] S_QEV   = 5'd15;
    localparam logic [4:0] S_LRD   = 5'd16;
    localparam logic [4:0] S_LEV   = 5'd17;
    localparam logic [4:0] S_FDIV  = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    // Configuration registers
    logic [AW-1:0]      r_base;
    logic [SHIFT_W-1:0] r_shift;
    logic [PCNT_W-1:0]  r_ptotal;
    logic [PCNT_W-1:0]  r_resv;

    // Sequencer state
    logic [4:0]  r_state, n_state;
    t_req_type   r_type, n_type;
    logic [PCNT_W-1:0] r_n, n_n;
    logic [AW-1:0] r_tgt, n_tgt, r_aln, n_aln;
    logic [IW-1:0] r_ss, n_ss;
    logic [PW-1:0] r_free, n_free, r_used, n_used;
    logic [CB-1:0] r_acnt, n_acnt, r_fcnt, n_fcnt, r_xcnt, n_xcnt;
    logic [IW-1:0] r_idx, n_idx, r_ptr, n_ptr, r_s, n_s;
    logic [PW:0]   r_i, n_i;
    logic [WW-1:0] r_c, n_c, r_run, n_run;
    logic [PW-1:0] r_lrg, n_lrg, r_rlim, n_rlim;
    logic [AW-1:0] r_m, n_m;
    logic          r_mval, n_mval, r_from_init, n_from_init;
    t_status       r_status, n_status;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_qbit, n_qbit;
    logic [FRAG_W-1:0] r_frag, n_frag;

    // Datapath helpers
    logic [PW-1:0] t_eff, rclip;
    logic [AW-1:0] pmask, off, ap;
    logic          in_reg, unal, over, align_bad;
    logic [IW-1:0] s_idx;
    logic          mem_we, mem_wdata, bit_rd;
    logic          div_go, div_busy;
    logic [DW-1:0] div_dvd, div_quot;
    logic [VW-1:0] div_dvs, div_rem;
    logic          adv_last;
    logic [IW-1:0] adv_idx;
    logic [AW-1:0] adv_m;
    logic [WW-1:0] run1;
    logic [PW-1:0] lrg1;
    logic [WW-1:0] sum_sn;

    // Effective page total and reserved clip
    always_comb begin
        if (r_ptotal == '0) begin
            t_eff = PW'(1);
        end else if (WW'(r_ptotal) > WW'(NUM_PAGES)) begin
            t_eff = PW'(NUM_PAGES);
        end else begin
            t_eff = PW'(r_ptotal);
        end
        rclip = (WW'(r_resv) > WW'(t_eff)) ? t_eff : PW'(r_resv);
    end

    // Address mapping checks
    assign pmask     = ~({AW{1'b1}} << r_shift);
    assign off       = (r_tgt - r_base) >> r_shift;
    assign in_reg    = (r_tgt >= r_base) && (XW'(off) < XW'(t_eff));
    assign s_idx     = off[IW-1:0];
    assign unal      = (r_tgt & pmask) != '0;
    assign over      = (WW'(s_idx) + WW'(r_n)) > WW'(t_eff);
    assign ap        = r_aln >> r_shift;
    assign align_bad = (r_aln == '0) || ((r_aln & pmask) != '0);
    assign sum_sn    = WW'(r_idx) + WW'(r_n);

    // Next aligned candidate
    always_comb begin
        adv_last = (r_i + (PW+1)'(1)) == (PW+1)'(t_eff);
        adv_idx  = ((PW'(r_idx) + PW'(1)) == t_eff) ? '0 : r_idx + IW'(1);
        if (adv_idx == '0) begin
            adv_m = '0;
        end else begin
            adv_m = ((r_m + AW'(1)) == ap) ? '0 : r_m + AW'(1);
        end
    end

    // Free-run tracking for the stats scan
    assign run1 = bit_rd ? '0 : r_run + WW'(1);
    assign lrg1 = (WW'(r_lrg) < run1) ? PW'(run1) : r_lrg;

    // Map write data
    assign mem_wdata = (r_state == S_CLR) ? (PW'(r_ptr) < r_rlim) : r_mval;

    // Sequencer
    always_comb begin
        logic [WW-1:0] prun;
        logic [WW-1:0] fend;
        n_state = r_state;   n_type = r_type;   n_n = r_n;
        n_tgt = r_tgt;       n_aln = r_aln;     n_ss = r_ss;
        n_free = r_free;     n_used = r_used;
        n_acnt = r_acnt;     n_fcnt = r_fcnt;   n_xcnt = r_xcnt;
        n_idx = r_idx;       n_ptr = r_ptr;     n_s = r_s;
        n_i = r_i;           n_c = r_c;         n_run = r_run;
        n_lrg = r_lrg;       n_rlim = r_rlim;   n_m = r_m;
        n_mval = r_mval;     n_from_init = r_from_init;
        n_status = r_status; n_addr = r_addr;   n_qbit = r_qbit;
        n_frag = r_frag;
        mem_we = 1'b0;
        div_go = 1'b0;
        div_dvd = '0;
        div_dvs = '0;
        prun = ((r_ptr == '0) ? '0 : r_run);
        prun = bit_rd ? '0 : prun + WW'(1);
        fend = WW'(r_ptr) + WW'(1) - WW'(r_n);

        unique case (r_state)
            // Sweep the whole map: reserved pages used, the rest free
            S_CLR: begin
                mem_we = 1'b1;
                if (r_ptr == IW'(NUM_PAGES - 1)) begin
                    n_ptr = '0;
                    n_from_init = 1'b0;
                    if (r_from_init) begin
                        n_free = t_eff - r_rlim;
                        n_used = r_rlim;
                        n_ss = (r_rlim == t_eff) ? '0 : IW'(r_rlim);
                        n_acnt = '0;
                        n_fcnt = '0;
                        n_xcnt = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
            // Take a request
            S_IDLE: begin
                if (i_start) begin
                    n_type = i_req_type;
                    n_n = i_page_count;
                    n_tgt = i_target_address;
                    n_aln = i_alignment_bytes;
                    n_status = ST_OK;
                    n_addr = '0;
                    n_qbit = 1'b0;
                    n_lrg = '0;
                    n_frag = '0;
                    n_state = S_PREP;
                end
            end
            // Check the request and pick its walk
            S_PREP: begin
                unique case (r_type)
                    REQ_ALLOC, REQ_ALIGN: begin
                        if (r_type == REQ_ALIGN && align_bad) begin
                            n_status = ST_BAD;
                            n_state = S_DONE;
                        end else if (r_n == '0) begin
                            n_status = ST_BAD;
                            n_xcnt = r_xcnt + CB'(1);
                            n_state = S_DONE;
                        end else if (WW'(r_n) > WW'(r_free) || WW'(r_n) > WW'(t_eff)) begin
                            n_status = ST_NOFIT;
                            n_xcnt = r_xcnt + CB'(1);
                            n_state = S_DONE;
                        end else begin
                            div_go = 1'b1;
                            div_dvd = DW'(r_ss);
                            div_dvs = VW'(t_eff);
                            n_state = S_DIVS;
                        end
                    end
                    REQ_AT: begin
                        if (unal || !in_reg || over) begin
                            n_status = ST_BAD;
                            n_state = S_DONE;
                        end else begin
                            n_s = s_idx;
                            n_ptr = s_idx;
                            n_c = '0;
                            n_mval = 1'b1;
                            n_state = (r_n == '0) ? S_FIN : S_CRD;
                        end
                    end
                    REQ_FREE: begin
                        if (r_tgt == '0 || r_n == '0 || unal || !in_reg || over) begin
                            n_status = ST_BAD;
                            n_state = S_DONE;
                        end else begin
                            n_s = s_idx;
                            n_ptr = s_idx;
                            n_c = '0;
                            n_mval = 1'b0;
                            n_state = S_MARK;
                        end
                    end
                    REQ_QUERY: begin
                        if (in_reg) begin
                            n_ptr = s_idx;
                            n_state = S_QRD;
                        end else begin
                            n_status = ST_BAD;
                            n_state = S_DONE;
                        end
                    end
                    REQ_STATS: begin
                        n_ptr = '0;
                        n_run = '0;
                        n_lrg = '0;
                        n_state = S_LRD;
                    end
                    REQ_RSTAT: begin
                        n_acnt = '0;
                        n_fcnt = '0;
                        n_xcnt = '0;
                        n_state = S_DONE;
                    end
                    REQ_INIT: begin
                        n_rlim = rclip;
                        n_ptr = '0;
                        n_from_init = 1'b1;
                        n_state = S_CLR;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // Start page is ready
            S_DIVS: begin
                if (!div_busy) begin
                    n_i = '0;
                    if (r_type == REQ_ALLOC) begin
                        n_ptr = IW'(div_rem);
                        n_run = '0;
                        n_state = S_PRD;
                    end else begin
                        n_idx = IW'(div_rem);
                        div_go = 1'b1;
                        div_dvd = DW'(IW'(div_rem));
                        div_dvs = VW'(ap);
                        n_state = S_DIVA;
                    end
                end
            end
            // Start page offset within the alignment is ready
            S_DIVA: begin
                if (!div_busy) begin
                    n_m = AW'(div_rem);
                    n_state = S_ASTEP;
                end
            end
            S_PRD: n_state = S_PEV;
            // Next-fit step; runs restart at page zero
            S_PEV: begin
                n_run = prun;
                if (prun == WW'(r_n)) begin
                    n_s = IW'(fend);
                    n_ptr = IW'(fend);
                    n_c = '0;
                    n_mval = 1'b1;
                    n_ss = ((WW'(r_ptr) + WW'(1)) == WW'(t_eff)) ? '0 : r_ptr + IW'(1);
                    n_state = S_MARK;
                end else if ((r_i + (PW+1)'(1)) == ((PW+1)'(t_eff) << 1)) begin
                    n_status = ST_NOFIT;
                    n_xcnt = r_xcnt + CB'(1);
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + (PW+1)'(1);
                    n_ptr = ((PW'(r_ptr) + PW'(1)) == t_eff) ? '0 : r_ptr + IW'(1);
                    n_state = S_PRD;
                end
            end
            // Aligned candidate: check it or move on
            S_ASTEP: begin
                if (r_m == '0) begin
                    n_ptr = r_idx;
                    n_c = '0;
                    n_state = S_ARD;
                end else if (adv_last) begin
                    n_status = ST_NOFIT;
                    n_xcnt = r_xcnt + CB'(1);
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + (PW+1)'(1);
                    n_idx = adv_idx;
                    n_m = adv_m;
                end
            end
            S_ARD: n_state = S_AEV;
            // Walk the run ahead of an aligned candidate
            S_AEV: begin
                if (!bit_rd && (r_c + WW'(1)) == WW'(r_n)) begin
                    n_s = r_idx;
                    n_ptr = r_idx;
                    n_c = '0;
                    n_mval = 1'b1;
                    n_ss = (sum_sn == WW'(t_eff)) ? '0 : IW'(sum_sn);
                    n_state = S_MARK;
                end else if (!bit_rd && (WW'(r_ptr) + WW'(1)) < WW'(t_eff)) begin
                    n_ptr = r_ptr + IW'(1);
                    n_c = r_c + WW'(1);
                    n_state = S_ARD;
                end else if (adv_last) begin
                    n_status = ST_NOFIT;
                    n_xcnt = r_xcnt + CB'(1);
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + (PW+1)'(1);
                    n_idx = adv_idx;
                    n_m = adv_m;
                    n_state = S_ASTEP;
                end
            end
            S_CRD: n_state = S_CEV;
            // Target run must be all free
            S_CEV: begin
                if (bit_rd) begin
                    n_status = ST_BUSY;
                    n_state = S_DONE;
                end else if ((r_c + WW'(1)) == WW'(r_n)) begin
                    n_ptr = r_s;
                    n_c = '0;
                    n_state = S_MARK;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                    n_c = r_c + WW'(1);
                    n_state = S_CRD;
                end
            end
            // Write the run, one page a cycle
            S_MARK: begin
                mem_we = 1'b1;
                if ((r_c + WW'(1)) == WW'(r_n)) begin
                    n_state = S_FIN;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                    n_c = r_c + WW'(1);
                end
            end
            // Update page counts and counters
            S_FIN: begin
                if (r_type == REQ_FREE) begin
                    n_free = ((WW'(r_free) + WW'(r_n)) > WW'(t_eff)) ? t_eff
                           : PW'(WW'(r_free) + WW'(r_n));
                    n_used = (WW'(r_n) > WW'(r_used)) ? '0 : PW'(WW'(r_used) - WW'(r_n));
                    n_fcnt = r_fcnt + CB'(1);
                end else begin
                    n_free = (WW'(r_n) > WW'(r_free)) ? '0 : PW'(WW'(r_free) - WW'(r_n));
                    n_used = ((WW'(r_used) + WW'(r_n)) > WW'(t_eff)) ? t_eff
                           : PW'(WW'(r_used) + WW'(r_n));
                    n_acnt = r_acnt + CB'(1);
                    n_addr = (r_type == REQ_AT) ? r_tgt : r_base + (AW'(r_s) << r_shift);
                end
                n_state = S_DONE;
            end
            S_QRD: n_state = S_QEV;
            S_QEV: begin
                n_qbit = bit_rd;
                n_state = S_DONE;
            end
            S_LRD: n_state = S_LEV;
            // Longest free run over the region
            S_LEV: begin
                n_run = run1;
                n_lrg = lrg1;
                if ((PW'(r_ptr) + PW'(1)) == t_eff) begin
                    if (r_free != '0 && lrg1 != '0 && lrg1 <= r_free) begin
                        div_go = 1'b1;
                        div_dvd = DW'(PCT_SCALE) * DW'(r_free - lrg1);
                        div_dvs = VW'(r_free);
                        n_state = S_FDIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_ptr = r_ptr + IW'(1);
                    n_state = S_LRD;
                end
            end
            S_FDIV: begin
                if (!div_busy) begin
                    n_frag = FRAG_W'(div_quot);
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ptr <= '0;
            r_rlim <= '0;
            r_from_init <= 1'b0;
            r_ss <= '0;
            r_free <= '0;
            r_used <= '0;
            r_acnt <= '0;
            r_fcnt <= '0;
            r_xcnt <= '0;
        end else begin
            r_state <= n_state;
            r_ptr <= n_ptr;
            r_rlim <= n_rlim;
            r_from_init <= n_from_init;
            r_ss <= n_ss;
            r_free <= n_free;
            r_used <= n_used;
            r_acnt <= n_acnt;
            r_fcnt <= n_fcnt;
            r_xcnt <= n_xcnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_n <= n_n;
        r_tgt <= n_tgt;
        r_aln <= n_aln;
        r_idx <= n_idx;
        r_s <= n_s;
        r_i <= n_i;
        r_c <= n_c;
        r_run <= n_run;
        r_lrg <= n_lrg;
        r_m <= n_m;
        r_mval <= n_mval;
        r_status <= n_status;
        r_addr <= n_addr;
        r_qbit <= n_qbit;
        r_frag <= n_frag;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_shift <= SHIFT_W'(12);
            r_ptotal <= PCNT_W'(1024);
            r_resv <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE:  r_base <= i_cfg_data;
                CFG_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_TOTAL: r_ptotal <= i_cfg_data[PCNT_W-1:0];
                CFG_RESV:  r_resv <= i_cfg_data[PCNT_W-1:0];
                default:   r_resv <= r_resv;
            endcase
        end
    end

    bpa_bitmap #(
        .DEPTH (NUM_PAGES),
        .IW    (IW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ptr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (bit_rd)
    );

    bpa_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Outputs
    assign o_busy                  = r_state != S_IDLE;
    assign o_done                  = r_state == S_DONE;
    assign o_cfg_ready             = 1'b1;
    assign o_status                = r_status;
    assign o_result_address        = r_addr;
    assign o_page_is_allocated     = r_qbit;
    assign o_free_pages            = PCNT_W'(r_free);
    assign o_used_pages            = PCNT_W'(r_used);
    assign o_largest_free_run      = PCNT_W'(r_lrg);
    assign o_fragmentation_percent = r_frag;
    assign o_alloc_total           = r_acnt;
    assign o_free_total            = r_fcnt;
    assign o_failure_total         = r_xcnt;

`ifndef ASSERT_OFF
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_result_address == '0)
        else $error("address on failed request");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy) else $error("divider busy when idle");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the bitmap page allocator: a shadow page map predicts each response.
import bpa_pkg::*;

typedef struct packed {
    t_status     status;
    logic [47:0] addr;
    logic        hit;
    logic [10:0] free_pg;
    logic [10:0] used_pg;
    logic [10:0] largest;
    logic [6:0]  frag;
    logic [31:0] allocs;
    logic [31:0] frees;
    logic [31:0] fails;
} t_page_resp;

class page_map_scoreboard;
    // Register copies
    logic [47:0] base;
    logic [4:0]  shift;
    logic [10:0] total_reg;
    logic [10:0] resv_reg;
    // Shadow allocator state
    bit          used_map[1024];
    int unsigned next_fit;
    int unsigned free_cnt;
    int unsigned used_cnt;
    logic [31:0] allocs;
    logic [31:0] frees;
    logic [31:0] fails;
    int unsigned run_len[1024];
    t_page_resp  awaited[$];
    int          mismatches;
    int          checked;

    function new();
        base = '0;
        shift = 5'd12;
        total_reg = 11'd1024;
        resv_reg = '0;
        foreach (used_map[i]) used_map[i] = 0;
        next_fit = 0;
        free_cnt = 0;
        used_cnt = 0;
        allocs = '0;
        frees = '0;
        fails = '0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [47:0] data);
        case (idx)
            CFG_BASE:  base = data;
            CFG_SHIFT: shift = data[4:0];
            CFG_TOTAL: total_reg = data[10:0];
            default:   resv_reg = data[10:0];
        endcase
    endfunction

    function int unsigned pages_managed();
        if (total_reg == 0) return 1;
        if (total_reg > 1024) return 1024;
        return total_reg;
    endfunction

    // Map an address to a page index; 0 when outside the region
    function bit page_of(logic [47:0] a, int unsigned t, output int unsigned idx);
        logic [63:0] off;
        idx = 0;
        if (a < base) return 0;
        off = 64'(a - base) >> shift;
        if (off >= 64'(t)) return 0;
        idx = int'(off);
        return 1;
    endfunction

    function logic [47:0] addr_of(int unsigned i);
        logic [63:0] a;
        a = 64'(base) + (64'(i) << shift);
        return a[47:0];
    endfunction

    function void mark(int unsigned s, int unsigned n, bit v);
        for (int unsigned k = 0; k < n && s + k < 1024; k++) used_map[s + k] = v;
    endfunction

    function void take(int unsigned n, int unsigned t);
        free_cnt = (n > free_cnt) ? 0 : free_cnt - n;
        used_cnt = (used_cnt + n > t) ? t : used_cnt + n;
        allocs++;
    endfunction

    function bit next_fit_search(int unsigned n, int unsigned t, output int unsigned found);
        int unsigned from, run, idx;
        from = next_fit % t;
        run = 0;
        found = 0;
        for (int unsigned i = 0; i < 2 * t; i++) begin
            idx = (from + i) % t;
            if (idx == 0) run = 0;
            if (used_map[idx]) begin
                run = 0;
            end else begin
                run++;
                if (run == n) begin
                    found = idx + 1 - n;
                    next_fit = (found + n) % t;
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function bit aligned_search(int unsigned n, logic [63:0] ap, int unsigned t,
                                output int unsigned found);
        int unsigned from, acc, idx;
        from = next_fit % t;
        acc = 0;
        found = 0;
        for (int i = int'(t) - 1; i >= 0; i--) begin
            acc = used_map[i] ? 0 : acc + 1;
            run_len[i] = acc;
        end
        for (int unsigned i = 0; i < t; i++) begin
            idx = (from + i) % t;
            if (64'(idx) % ap == 0 && run_len[idx] >= n) begin
                found = idx;
                next_fit = (idx + n) % t;
                return 1;
            end
        end
        return 0;
    endfunction

    // Work out the response to an accepted request and queue it
    function void note_request(t_req_type kind, logic [10:0] cnt, logic [47:0] target,
                               logic [47:0] align);
        t_page_resp  r;
        int unsigned t, n, s, run;
        logic [47:0] pmask;
        bit          ok;
        t = pages_managed();
        n = cnt;
        s = 0;
        pmask = (48'd1 << shift) - 48'd1;
        r.status = ST_OK;
        r.addr = '0;
        r.hit = 0;
        r.largest = '0;
        r.frag = '0;
        case (kind)
            REQ_ALLOC, REQ_ALIGN: begin
                if (kind == REQ_ALIGN && (align == 0 || (align & pmask) != 0)) begin
                    r.status = ST_BAD;
                end else if (n == 0) begin
                    r.status = ST_BAD;
                    fails++;
                end else begin
                    ok = 0;
                    if (n <= free_cnt && n <= t) begin
                        if (kind == REQ_ALLOC) ok = next_fit_search(n, t, s);
                        else ok = aligned_search(n, 64'(align >> shift), t, s);
                    end
                    if (!ok) begin
                        r.status = ST_NOFIT;
                        fails++;
                    end else begin
                        mark(s, n, 1);
                        take(n, t);
                        r.addr = addr_of(s);
                    end
                end
            end
            REQ_AT: begin
                if ((target & pmask) != 0 || !page_of(target, t, s) || s + n > t) begin
                    r.status = ST_BAD;
                end else begin
                    for (int unsigned k = 0; k < n; k++)
                        if (used_map[s + k]) r.status = ST_BUSY;
                    if (r.status == ST_OK) begin
                        mark(s, n, 1);
                        take(n, t);
                        r.addr = target;
                    end
                end
            end
            REQ_FREE: begin
                if (target == 0 || n == 0 || (target & pmask) != 0 ||
                    !page_of(target, t, s) || s + n > t) begin
                    r.status = ST_BAD;
                end else begin
                    mark(s, n, 0);
                    free_cnt = (free_cnt + n > t) ? t : free_cnt + n;
                    used_cnt = (n > used_cnt) ? 0 : used_cnt - n;
                    frees++;
                end
            end
            REQ_QUERY: begin
                if (page_of(target, t, s)) r.hit = used_map[s];
                else r.status = ST_BAD;
            end
            REQ_STATS: begin
                run = 0;
                for (int unsigned k = 0; k < t; k++) begin
                    run = used_map[k] ? 0 : run + 1;
                    if (run > r.largest) r.largest = 11'(run);
                end
                if (free_cnt > 0 && r.largest > 0 && r.largest <= free_cnt)
                    r.frag = 7'((PCT_SCALE * (free_cnt - r.largest)) / free_cnt);
            end
            REQ_RSTAT: begin
                allocs = '0;
                frees = '0;
                fails = '0;
            end
            default: begin
                run = (resv_reg > t) ? t : resv_reg;
                foreach (used_map[i]) used_map[i] = 0;
                mark(0, run, 1);
                free_cnt = t - run;
                used_cnt = run;
                next_fit = run % t;
                allocs = '0;
                frees = '0;
                fails = '0;
            end
        endcase
        r.free_pg = 11'(free_cnt);
        r.used_pg = 11'(used_cnt);
        r.allocs = allocs;
        r.frees = frees;
        r.fails = fails;
        awaited.push_back(r);
    endfunction

    function void check_response(t_page_resp got);
        t_page_resp want;
        checked++;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response, none pending");
            return;
        end
        want = awaited.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on response %0d:", checked);
                $display("  exp st=%0d a=%h q=%0d f=%0d u=%0d l=%0d fr=%0d c=%0d/%0d/%0d",
                         want.status, want.addr, want.hit, want.free_pg, want.used_pg,
                         want.largest, want.frag, want.allocs, want.frees, want.fails);
                $display("  got st=%0d a=%h q=%0d f=%0d u=%0d l=%0d fr=%0d c=%0d/%0d/%0d",
                         got.status, got.addr, got.hit, got.free_pg, got.used_pg,
                         got.largest, got.frag, got.allocs, got.frees, got.fails);
            end
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 400_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_req_type   i_req_type;
    logic [10:0] i_page_count;
    logic [47:0] i_target_address;
    logic [47:0] i_alignment_bytes;
    logic        o_done;
    t_status     o_status;
    logic [47:0] o_result_address;
    logic        o_page_is_allocated;
    logic [10:0] o_free_pages;
    logic [10:0] o_used_pages;
    logic [10:0] o_largest_free_run;
    logic [6:0]  o_fragmentation_percent;
    logic [31:0] o_alloc_total;
    logic [31:0] o_free_total;
    logic [31:0] o_failure_total;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [47:0] i_cfg_data;

    page_map_scoreboard pages;
    longint             cycles;
    int                 sent;
    int                 phases;

    bitmap_page_allocator_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check each response strobe
    always @(posedge i_clk) begin
        t_page_resp got;
        if (i_rst_n && o_done) begin
            got.status = o_status;
            got.addr = o_result_address;
            got.hit = o_page_is_allocated;
            got.free_pg = o_free_pages;
            got.used_pg = o_used_pages;
            got.largest = o_largest_free_run;
            got.frag = o_fragmentation_percent;
            got.allocs = o_alloc_total;
            got.frees = o_free_total;
            got.fails = o_failure_total;
            pages.check_response(got);
        end
    end

    // Hold a request until accepted; keep start high across back-to-back requests
    task automatic send(t_req_type kind, logic [10:0] cnt, logic [47:0] target,
                        logic [47:0] align);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req_type <= kind;
        i_page_count <= cnt;
        i_target_address <= target;
        i_alignment_bytes <= align;
        do @(posedge i_clk); while (o_busy);
        pages.note_request(kind, cnt, target, align);
        sent++;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pages.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Hold a register write until taken; the caller drops valid
    task automatic write_reg(t_cfg_idx idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pages.write_reg(idx, data);
    endtask

    task automatic set_region(logic [47:0] base, logic [4:0] shift, logic [10:0] total,
                              logic [10:0] resv);
        drain();
        write_reg(CFG_BASE, base);
        write_reg(CFG_SHIFT, 48'(shift));
        write_reg(CFG_TOTAL, 48'(total));
        write_reg(CFG_RESV, 48'(resv));
        i_cfg_valid <= 1'b0;
        phases++;
        send(REQ_INIT, '0, '0, '0);
    endtask

    function automatic logic [47:0] page_addr(int unsigned idx);
        return pages.addr_of(idx);
    endfunction

    // Mostly in-range page addresses, with some unaligned and wild ones
    function automatic logic [47:0] pick_target();
        int unsigned t;
        int          roll;
        t = pages.pages_managed();
        roll = $urandom_range(0, 19);
        if (roll == 0) return 48'({$urandom(), $urandom()});
        if (roll == 1) return page_addr($urandom_range(0, t - 1)) + 48'd1;
        if (roll == 2) return pages.base - 48'd1;
        return page_addr($urandom_range(0, t));
    endfunction

    function automatic logic [10:0] pick_count();
        int unsigned t;
        int          roll;
        t = pages.pages_managed();
        roll = $urandom_range(0, 19);
        if (roll == 0) return 11'($urandom());
        if (roll < 3) return 11'($urandom_range(0, t + 1));
        return 11'($urandom_range(0, (t < 8) ? t : t / 4 + 1));
    endfunction

    function automatic logic [47:0] pick_align();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return 48'({$urandom(), $urandom()});
        if (roll == 2) return (48'd1 << pages.shift) + 48'd1;
        return 48'($urandom_range(1, 8)) << pages.shift;
    endfunction

    task automatic random_requests(int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) send(REQ_ALLOC, pick_count(), pick_target(), pick_align());
            else if (roll < 38) send(REQ_ALIGN, pick_count(), pick_target(), pick_align());
            else if (roll < 53) send(REQ_AT, pick_count(), pick_target(), pick_align());
            else if (roll < 75) send(REQ_FREE, pick_count(), pick_target(), pick_align());
            else if (roll < 85) send(REQ_QUERY, pick_count(), pick_target(), pick_align());
            else if (roll < 93) send(REQ_STATS, pick_count(), pick_target(), pick_align());
            else if (roll < 96) send(REQ_RSTAT, pick_count(), pick_target(), pick_align());
            else send(REQ_INIT, pick_count(), pick_target(), pick_align());
            // Let the map settle now and then
            if ($urandom_range(0, 59) == 0) drain();
        end
    endtask

    initial begin
        logic [47:0] b;
        pages = new();
        sent = 0;
        phases = 0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_req_type <= REQ_QUERY;
        i_page_count <= '0;
        i_target_address <= '0;
        i_alignment_bytes <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BASE;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: small region with two reserved pages
        b = 48'h0000_1000_0000;
        set_region(b, 5'd12, 11'd16, 11'd2);
        send(REQ_ALLOC, 11'd0, '0, '0);
        send(REQ_ALLOC, 11'd4, '0, '0);
        send(REQ_ALLOC, 11'd16, '0, '0);
        send(REQ_ALLOC, 11'h7FF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send(REQ_ALIGN, 11'd2, '0, '0);
        send(REQ_ALIGN, 11'd2, '0, 48'h1001);
        send(REQ_ALIGN, 11'd3, '0, 48'h4000);
        send(REQ_AT, 11'd1, b, '0);
        send(REQ_AT, 11'd1, b + 48'h10, '0);
        send(REQ_AT, 11'd1, b + 48'h10_0000, '0);
        send(REQ_AT, 11'd0, b + 48'hF000, '0);
        send(REQ_AT, 11'd2, b + 48'hF000, '0);
        send(REQ_AT, 11'd1, b + 48'hF000, '0);
        send(REQ_FREE, 11'd1, '0, '0);
        send(REQ_FREE, 11'd0, b + 48'h2000, '0);
        send(REQ_FREE, 11'd2, b + 48'h2000, '0);
        send(REQ_FREE, 11'd3, b + 48'hE000, '0);
        send(REQ_FREE, 11'd3, b + 48'hA000, '0);
        send(REQ_QUERY, '0, b, '0);
        send(REQ_QUERY, '0, b + 48'h5000, '0);
        send(REQ_QUERY, '0, 48'hFFFF_FFFF_FFFF, '0);
        send(REQ_STATS, '0, '0, '0);
        send(REQ_RSTAT, '0, '0, '0);
        send(REQ_STATS, '0, '0, '0);
        random_requests(60);

        // Pause until every response is back, then continue in the same region
        drain();
        random_requests(20);

        // One-page region: total zero clips to one, reserve clips to the total
        set_region(48'({$urandom(), $urandom()}), 5'd0, 11'd0, 11'h7FF);
        random_requests(35);

        // Full map at the top of the address space with 2^30-byte pages
        set_region(48'hFFFF_FFFF_FFFF, 5'd30, 11'h7FF, 11'd0);
        random_requests(25);

        // Full map, all pages reserved
        set_region(48'd0, 5'd12, 11'd1024, 11'd1024);
        random_requests(25);

        // Assorted small regions
        for (int p = 0; p < 6; p++) begin
            set_region(48'({$urandom(), $urandom()}), 5'($urandom_range(0, 30)),
                       11'($urandom_range(8, 64)), 11'($urandom_range(0, 12)));
            random_requests(45);
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("sent %0d requests over %0d region settings, %0d responses checked",
                 sent, phases, pages.checked);
        $display("%0d mismatches, %0d responses still pending",
                 pages.mismatches, pages.awaited.size());
        if (pages.mismatches == 0 && pages.awaited.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
